// File: rtl/core/ptw_pkg.sv
package ptw_pkg;

  localparam int unsigned PHYS_ADDR_BITS = 52;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned IDX64_W = 9;
  localparam int unsigned IDX32_W = 10;

  localparam int unsigned S_TDATA_W = 168;
  localparam int unsigned M_TDATA_W = 56;

  localparam logic [PA_W-1:0] PHYS_MASK =
    PA_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);
  localparam logic [PA_W-1:0] TABLE_MASK   = 52'h3fffffffff000 & PHYS_MASK;
  localparam logic [PA_W-1:0] TOP_PS_MASK  = 52'h0ffffc0000000 & PHYS_MASK;
  localparam logic [PA_W-1:0] GIGA_MASK    = ~52'h3fffffff & PHYS_MASK;
  localparam logic [PA_W-1:0] MEGA2_MASK   = ~52'h1fffff & PHYS_MASK;
  localparam logic [PA_W-1:0] LEGACY_FRAME = 52'hfffff000;

  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_USER    = 2;
  localparam int unsigned BIT_CD      = 4;
  localparam int unsigned BIT_PS      = 7;

  localparam logic [1:0] LEVEL_TOP = 2'd0;
  localparam logic [1:0] LEVEL_PDP = 2'd1;
  localparam logic [1:0] LEVEL_PD  = 2'd2;
  localparam logic [1:0] LEVEL_PT  = 2'd3;

  typedef enum logic {
    KIND_TRANSLATE = 1'b0,
    KIND_RESPONSE  = 1'b1
  } item_kind_e;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_DONE = 1'b1
  } result_kind_e;

  typedef enum logic {
    MODE_LONG   = 1'b0,
    MODE_LEGACY = 1'b1
  } walk_mode_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [VA_W-1:0]   vaddr;
    logic [PA_W-1:0]   first_addr;
    logic [DATA_W-1:0] data;
    logic              ok;
  } ptw_item_t;

  typedef struct packed {
    result_kind_e    kind;
    logic [PA_W-1:0] addr;
    logic            found;
    logic            user;
    logic            cd;
  } ptw_result_t;

endpackage

// File: rtl/core/ptw_front.sv
module ptw_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               in_action_i,
  input  logic [ptw_pkg::S_TDATA_W-1:0]      in_data_i,
  output logic                               item_valid_o,
  output ptw_pkg::ptw_item_t                 item_o,
  input  logic                               pop_i,
  output ptw_pkg::walk_mode_e                mode_o
);
  import ptw_pkg::*;

  walk_mode_e       mode_q;
  ptw_item_t        entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             push;
  ptw_item_t        cls;
  logic [VA_W-1:0]  va;
  logic [PA_W-1:0]  root;

  assign va   = in_data_i[47:0];
  assign root = in_data_i[99:48];

  // classify the beat and form the first entry address of a request
  always_comb begin
    cls.kind  = item_kind_e'(in_action_i);
    cls.vaddr = va;
    cls.data  = in_data_i[163:100];
    cls.ok    = in_data_i[164];
    if (mode_q == MODE_LEGACY) begin
      cls.first_addr = (root & LEGACY_FRAME) + {40'd0, va[31:22], 2'b00};
    end else begin
      cls.first_addr = (root & TABLE_MASK) + {40'd0, va[47:39], 3'b000};
    end
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i & in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign mode_o       = mode_q;

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LONG;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= walk_mode_e'(cfg_wdata_i);
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// File: rtl/core/ptw_back.sv
module ptw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptw_pkg::walk_mode_e mode_i,
  input  logic                item_valid_i,
  input  ptw_pkg::ptw_item_t  item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptw_pkg::ptw_result_t out_o
);
  import ptw_pkg::*;

  logic              walking_q, walking_d;
  logic [1:0]        level_q, level_d;
  logic [VA_W-1:0]   vaddr_q, vaddr_d;
  logic              user_q, user_d;
  logic              out_valid_q;
  ptw_result_t       out_q;

  logic              advance;
  logic              emit;
  ptw_result_t       res;
  logic [PA_W-1:0]   e52;
  logic [PA_W-1:0]   e32;
  logic [IDX64_W-1:0] idx;
  logic              user_now;

  assign advance = item_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o   = advance;

  assign e52      = item_i.data[PA_W-1:0];
  assign e32      = {20'd0, item_i.data[31:0]};
  assign user_now = user_q & item_i.data[BIT_USER];

  always_comb begin
    case (level_q)
      LEVEL_TOP: idx = vaddr_q[38:30];
      LEVEL_PDP: idx = vaddr_q[29:21];
      default:   idx = vaddr_q[20:12];
    endcase
  end

  always_comb begin
    walking_d = walking_q;
    level_d   = level_q;
    vaddr_d   = vaddr_q;
    user_d    = user_q;
    emit      = 1'b0;
    res       = '{kind: RES_READ, addr: '0, found: 1'b0, user: 1'b0, cd: 1'b0};

    if (item_i.kind == KIND_TRANSLATE) begin
      emit      = 1'b1;
      walking_d = 1'b1;
      level_d   = LEVEL_TOP;
      vaddr_d   = item_i.vaddr;
      user_d    = 1'b1;
      res.addr  = item_i.first_addr;
    end else if (walking_q) begin
      emit = 1'b1;
      if (!item_i.ok || !item_i.data[BIT_PRESENT]) begin
        // missing entry or failed read ends the walk
        walking_d = 1'b0;
        level_d   = LEVEL_TOP;
        res.kind  = RES_DONE;
      end else if (mode_i == MODE_LEGACY) begin
        if (level_q == LEVEL_TOP) begin
          level_d  = LEVEL_PDP;
          res.addr = (e32 & LEGACY_FRAME) + {40'd0, vaddr_q[21:12], 2'b00};
        end else begin
          walking_d = 1'b0;
          level_d   = LEVEL_TOP;
          res.kind  = RES_DONE;
          res.found = 1'b1;
          res.addr  = ((e32 & LEGACY_FRAME) | {40'd0, vaddr_q[11:0]}) & PHYS_MASK;
        end
      end else begin
        user_d = user_now;
        if (level_q == LEVEL_PT || item_i.data[BIT_PS]) begin
          walking_d = 1'b0;
          level_d   = LEVEL_TOP;
          res.kind  = RES_DONE;
          res.found = 1'b1;
          res.user  = user_now;
          res.cd    = (level_q != LEVEL_TOP) & item_i.data[BIT_CD];
          case (level_q)
            LEVEL_TOP: res.addr = (e52 & TOP_PS_MASK) | {22'd0, vaddr_q[29:0]};
            LEVEL_PDP: res.addr = (e52 & GIGA_MASK) | {22'd0, vaddr_q[29:0]};
            LEVEL_PD:  res.addr = (e52 & MEGA2_MASK) | {31'd0, vaddr_q[20:0]};
            default:   res.addr = (e52 & TABLE_MASK) | {40'd0, vaddr_q[11:0]};
          endcase
        end else begin
          level_d  = level_q + 2'd1;
          res.addr = (e52 & TABLE_MASK) + {40'd0, idx, 3'b000};
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q   <= 1'b0;
      level_q     <= LEVEL_TOP;
      vaddr_q     <= '0;
      user_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        walking_q <= walking_d;
        level_q   <= level_d;
        vaddr_q   <= vaddr_d;
        user_q    <= user_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

endmodule

// File: rtl/core/page_table_walker_core.sv
// page table walker, four-level long mode or two-level legacy mode
// the slave stream carries translate requests (tuser = 0) and memory read
// responses (tuser = 1); each request beat yields a read request beat for the
// top-level entry, and each response beat yields either the next read request
// or a finished translation (master tuser = 1); a response with no walk in
// progress yields nothing, and a request during a walk restarts the walk
// a beat goes through the queue register and the output register to the
// master side; throughput is one beat per cycle while results are taken,
// set by the combinational entry decode in the back end
// a two-entry queue separates the input classification from the walk state,
// so input beats keep being taken while a result waits on the master side;
// with the master stalled the queue fills and s_axis_tready drops
// reset clears the walk state, the queue and the output register, and sets
// walk_mode to long mode; write walk_mode through cfg_we_i only when no walk
// is in progress and all results have been taken
module page_table_walker_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,   // walk_mode
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // virtual_address[47:0], table_root[99:48], read_data[163:100],
  // read_ok[164], zero pad[167:165]
  input  logic [ptw_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,  // action
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_address[51:0], found[52], user_page[53], cache_disabled[54], pad[55]
  output logic [ptw_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tuser   // result_kind
);
  import ptw_pkg::*;

  logic        item_valid;
  ptw_item_t   item;
  logic        pop;
  walk_mode_e  mode;
  ptw_result_t res;

  ptw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop),
    .mode_o       (mode)
  );

  ptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {1'b0, res.cd, res.user, res.found, res.addr};

endmodule
